/* src/cfc_pkg.sv */
`default_nettype none

package cfc_pkg;

  localparam int unsigned FrameLen  = 10;
  localparam int unsigned DataLen   = 8;
  localparam int unsigned NumChan   = 4;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned SampleW   = 16;
  localparam int unsigned DataW     = DataLen * ByteW;
  localparam int unsigned CntW      = $clog2(FrameLen);

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam logic [CntW-1:0] CntCrcLo = CntW'(DataLen);
  localparam logic [CntW-1:0] CntLast  = CntW'(FrameLen - 1);

  typedef logic [ByteW-1:0]  byte_t;
  typedef logic [15:0]       crc_t;
  typedef logic [CntW-1:0]   cnt_t;

  // One byte of reflected CRC-16: xor in the byte, then eight shift/xor steps.
  function automatic crc_t crc_byte(input crc_t crc_in, input byte_t data);
    crc_t c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* src/four_channel_frame_crc16_modbus.sv */
`default_nettype none

// Four-channel sample framer with CRC-16/MODBUS. Each input beat carries
// four 16-bit samples; the block answers with ten output beats: the samples
// in channel order 0..3, low byte first, then the CRC-16/MODBUS over those
// eight bytes (poly 0xA001 reflected, init 0xFFFF, no final xor), low byte
// first. frame_end_o marks the tenth beat. Bytes leave through a single
// output byte lane, one per cycle while out_stall_i is low. An input beat
// waits in a one-deep holding register while the previous frame drains, and
// the next frame starts in the cycle after the last byte of the prior one.
// When idle, an input beat passes through the holding register and then the
// byte cells before its first output byte appears.
module four_channel_frame_crc16_modbus (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  wire signed [15:0] sample_zero_i,
  input  wire signed [15:0] sample_one_i,
  input  wire signed [15:0] sample_two_i,
  input  wire signed [15:0] sample_three_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output logic [7:0]        frame_byte_o,
  output logic              frame_end_o
);
  import cfc_pkg::*;

  // Holding register for one accepted beat.
  logic             pend_vld_q, pend_vld_d;
  logic [DataW-1:0] pend_q;

  // Frame control.
  logic busy_q, busy_d;
  cnt_t cnt_q, cnt_d;

  logic in_acc, out_acc, last_acc, load, shift;

  byte_t cell_byte [DataLen];
  byte_t cell_next [DataLen];
  crc_t  crc;

  assign in_stall_o = pend_vld_q;
  assign in_acc     = in_valid_i & ~pend_vld_q;

  assign out_valid_o = busy_q;
  assign out_acc     = busy_q & ~out_stall_i;
  assign last_acc    = out_acc & (cnt_q == CntLast);
  assign load        = pend_vld_q & (~busy_q | last_acc);
  // Data bytes march toward cell 0 while they are being sent.
  assign shift       = out_acc & (cnt_q < CntCrcLo);

  always_comb begin
    pend_vld_d = pend_vld_q;
    if (load) begin
      pend_vld_d = 1'b0;
    end else if (in_acc) begin
      pend_vld_d = 1'b1;
    end
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (load) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (last_acc) begin
      busy_d = 1'b0;
    end else if (out_acc) begin
      cnt_d = cnt_q + cnt_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      busy_q     <= 1'b0;
      cnt_q      <= '0;
    end else begin
      pend_vld_q <= pend_vld_d;
      busy_q     <= busy_d;
      cnt_q      <= cnt_d;
    end
  end

  // Sample payload: channel 0 in the low bits, so byte i of the frame sits at [8i +: 8].
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pend_q <= {sample_three_i, sample_two_i, sample_one_i, sample_zero_i};
    end
  end

  // Row of byte cells; the far end shifts in zero.
  for (genvar i = 0; i < DataLen; i++) begin : g_cell
    if (i == DataLen - 1) begin : g_end
      assign cell_next[i] = '0;
    end else begin : g_mid
      assign cell_next[i] = cell_byte[i+1];
    end

    cfc_byte_cell u_cell (
      .clk_i       (clk_i),
      .load_i      (load),
      .shift_i     (shift),
      .load_byte_i (pend_q[ByteW*i +: ByteW]),
      .next_byte_i (cell_next[i]),
      .byte_o      (cell_byte[i])
    );
  end

  // CRC folds in each data byte as it leaves cell 0.
  cfc_crc_cell u_crc (
    .clk_i    (clk_i),
    .init_i   (load),
    .update_i (shift),
    .data_i   (cell_byte[0]),
    .crc_o    (crc)
  );

  always_comb begin
    if (cnt_q < CntCrcLo) begin
      frame_byte_o = cell_byte[0];
    end else if (cnt_q == CntCrcLo) begin
      frame_byte_o = crc[7:0];
    end else begin
      frame_byte_o = crc[15:8];
    end
  end

  assign frame_end_o = (cnt_q == CntLast);

endmodule

`default_nettype wire

/* src/cfc_byte_cell.sv */
`default_nettype none

module cfc_byte_cell (
  input  wire                 clk_i,
  input  wire                 load_i,
  input  wire                 shift_i,
  input  wire cfc_pkg::byte_t load_byte_i,
  input  wire cfc_pkg::byte_t next_byte_i,
  output      cfc_pkg::byte_t byte_o
);
  import cfc_pkg::*;

  byte_t byte_q, byte_d;

  // Load a fresh frame byte, or take the neighbor's byte as the frame moves out.
  always_comb begin
    byte_d = byte_q;
    if (load_i) begin
      byte_d = load_byte_i;
    end else if (shift_i) begin
      byte_d = next_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o = byte_q;

endmodule

`default_nettype wire

/* src/cfc_crc_cell.sv */
`default_nettype none

module cfc_crc_cell (
  input  wire                 clk_i,
  input  wire                 init_i,
  input  wire                 update_i,
  input  wire cfc_pkg::byte_t data_i,
  output      cfc_pkg::crc_t  crc_o
);
  import cfc_pkg::*;

  crc_t crc_q, crc_d;

  always_comb begin
    crc_d = crc_q;
    if (init_i) begin
      crc_d = CrcInit;
    end else if (update_i) begin
      crc_d = crc_byte(crc_q, data_i);
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q <= crc_d;
  end

  assign crc_o = crc_q;

endmodule

`default_nettype wire

/* sim/cfc_frame_checker.sv */
`timescale 1ns / 100ps

// Watches both channels of the framer, predicts the ten frame bytes of every
// accepted input beat and compares each accepted output beat in order.
module cfc_frame_checker (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  input  wire               in_stall_i,
  input  wire [15:0]        sample_zero_i,
  input  wire [15:0]        sample_one_i,
  input  wire [15:0]        sample_two_i,
  input  wire [15:0]        sample_three_i,
  input  wire               out_valid_i,
  input  wire               out_stall_i,
  input  wire [7:0]         frame_byte_i,
  input  wire               frame_end_i,
  output int unsigned       err_cnt_o,
  output int unsigned       pending_o
);
  import cfc_pkg::*;

  typedef struct packed {
    byte_t data;
    logic  last;
  } frame_beat_t;

  frame_beat_t frame_bytes_due [$];
  int unsigned mismatches    = 0;
  int unsigned beats_waiting = 0;

  assign err_cnt_o = mismatches;
  assign pending_o = beats_waiting;

  // Bitwise reflected CRC over the eight payload bytes, byte 0 in bits 7:0.
  function automatic crc_t modbus_crc(input logic [63:0] payload);
    crc_t acc;
    acc = CrcInit;
    for (int k = 0; k < DataLen; k++) begin
      acc = acc ^ {8'h00, payload[8*k +: 8]};
      for (int b = 0; b < 8; b++) begin
        if (acc[0]) begin
          acc = (acc >> 1) ^ CrcPoly;
        end else begin
          acc = acc >> 1;
        end
      end
    end
    return acc;
  endfunction

  always @(posedge clk_i) begin : watch
    frame_beat_t want;
    logic [63:0] payload;
    crc_t        crc;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        payload = {sample_three_i, sample_two_i, sample_one_i, sample_zero_i};
        crc     = modbus_crc(payload);
        for (int k = 0; k < DataLen; k++) begin
          frame_bytes_due.push_back({payload[8*k +: 8], 1'b0});
        end
        frame_bytes_due.push_back({crc[7:0], 1'b0});
        frame_bytes_due.push_back({crc[15:8], 1'b1});
      end
      if (out_valid_i && !out_stall_i) begin
        if (frame_bytes_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected frame beat, expected none, actual byte %02h end %0b",
                   $time, frame_byte_i, frame_end_i);
        end else begin
          want = frame_bytes_due.pop_front();
          if (frame_byte_i !== want.data) begin
            mismatches++;
            $display("%0t: frame_byte mismatch, expected %02h, actual %02h",
                     $time, want.data, frame_byte_i);
          end
          if (frame_end_i !== want.last) begin
            mismatches++;
            $display("%0t: frame_end mismatch, expected %0b, actual %0b",
                     $time, want.last, frame_end_i);
          end
        end
      end
      beats_waiting = frame_bytes_due.size();
    end
  end

endmodule

/* sim/four_channel_frame_crc16_modbus_tb.sv */
`timescale 1ns / 100ps

// Top of the framer bench: clock, reset, sample stimulus, output back-pressure
// and the verdict. All prediction and comparison lives in the checker.
module four_channel_frame_crc16_modbus_tb;

  localparam int unsigned RandomFrames = 480;
  localparam int unsigned HoldCycles   = 300;     // long receiver hold-off
  localparam int unsigned HoldAtFrame  = 150;
  localparam int unsigned PauseAtFrame = 320;     // sender drains the block here
  localparam int unsigned DrainCycles  = 30;      // idle run after the last byte
  localparam int unsigned LimitCycles  = 2000000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] sample_zero;
  logic signed [15:0] sample_one;
  logic signed [15:0] sample_two;
  logic signed [15:0] sample_three;
  logic               out_valid;
  logic               out_stall;
  logic [7:0]         frame_byte;
  logic               frame_end;

  int unsigned err_cnt;
  int unsigned pending;
  int unsigned cycle_cnt = 0;
  bit          hold_req  = 1'b0;   // set by the sender, cleared by the receiver

  logic [63:0] directed [$];       // {s0, s1, s2, s3}

  four_channel_frame_crc16_modbus i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .sample_zero_i  (sample_zero),
    .sample_one_i   (sample_one),
    .sample_two_i   (sample_two),
    .sample_three_i (sample_three),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .frame_byte_o   (frame_byte),
    .frame_end_o    (frame_end)
  );

  cfc_frame_checker i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .sample_zero_i  (sample_zero),
    .sample_one_i   (sample_one),
    .sample_two_i   (sample_two),
    .sample_three_i (sample_three),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .frame_byte_i   (frame_byte),
    .frame_end_i    (frame_end),
    .err_cnt_o      (err_cnt),
    .pending_o      (pending)
  );

  // 8 ns clock.
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LimitCycles) begin
      $display("%0t: watchdog expired", $time);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Offer one input beat, called at a falling edge. A nonzero gap drops valid
  // first; with zero gap valid is not dropped, so it gets
  // just the one assignment in this step. Returns at the falling edge after
  // the beat was taken.
  task automatic send_frame(input logic [15:0] s0, input logic [15:0] s1,
                            input logic [15:0] s2, input logic [15:0] s3,
                            input int unsigned gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    sample_zero  <= s0;
    sample_one   <= s1;
    sample_two   <= s2;
    sample_three <= s3;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Receiver back-pressure: alternating runs of stall and no stall, mostly
  // short, now and then long. On request it holds off for HoldCycles so the
  // holding register fills and the block stalls its input.
  initial begin : receiver
    int unsigned run_left;
    logic        stall_now;
    run_left  = 0;
    stall_now = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
        run_left = 0;
      end else begin
        if (run_left == 0) begin
          stall_now = !stall_now;
          if (stall_now) begin
            run_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                  : $urandom_range(10, 60);
          end else begin
            run_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 12)
                                                  : $urandom_range(40, 200);
          end
        end
        out_stall <= stall_now;
        run_left--;
      end
    end
  end

  // Stimulus and verdict.
  initial begin : sender
    logic [15:0] smp [4];
    int unsigned gap;
    int unsigned r;
    bit          burst;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    sample_zero  = '0;
    sample_one   = '0;
    sample_two   = '0;
    sample_three = '0;
    burst        = 1'b0;

    // Extremes of the 16-bit pattern, signed corners, byte order per channel,
    // alternating bit patterns.
    directed = '{
      64'h0000_0000_0000_0000,
      64'hFFFF_FFFF_FFFF_FFFF,
      64'h8000_8000_8000_8000,
      64'h7FFF_7FFF_7FFF_7FFF,
      64'h8000_7FFF_FFFF_0000,
      64'hFFFE_8001_0001_7FFE,
      64'h0001_0000_0000_0000,
      64'h0100_0000_0000_0000,
      64'h0000_0000_0000_0001,
      64'h0000_0000_0000_0100,
      64'hFFFF_0000_0000_0000,
      64'h0000_FFFF_0000_0000,
      64'h0000_0000_FFFF_0000,
      64'h0000_0000_0000_FFFF,
      64'hAAAA_5555_AAAA_5555,
      64'h5555_AAAA_5555_AAAA,
      64'hFF00_00FF_FF00_00FF,
      64'h1234_5678_9ABC_DEF0
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed frames: mix of back-to-back and spaced beats.
    foreach (directed[i]) begin
      send_frame(directed[i][63:48], directed[i][47:32], directed[i][31:16],
                 directed[i][15:0], i % 3);
    end

    // Sender pause: let the block drain fully before the random part.
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);

    for (int n = 0; n < RandomFrames; n++) begin
      // Switch between no-idle stretches and gappy stretches.
      if (n % 40 == 0) begin
        burst = ($urandom_range(0, 3) == 0);
      end
      if (n == HoldAtFrame) begin
        hold_req = 1'b1;
      end
      if (n == PauseAtFrame) begin
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
      end

      // Random samples, biased a bit toward the signed corners.
      for (int ch = 0; ch < 4; ch++) begin
        case ($urandom_range(0, 9))
          0:       smp[ch] = 16'h8000;
          1:       smp[ch] = 16'h7FFF;
          2:       smp[ch] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          default: smp[ch] = 16'($urandom);
        endcase
      end

      // Gaps: mostly none or short, a few long; none while the hold-off runs
      // so the sender keeps pushing into a full block.
      r = $urandom_range(0, 19);
      if (burst || hold_req) begin
        gap = 0;
      end else if (r < 12) begin
        gap = 0;
      end else if (r < 18) begin
        gap = $urandom_range(1, 3);
      end else begin
        gap = $urandom_range(10, 50);
      end

      send_frame(smp[0], smp[1], smp[2], smp[3], gap);
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);

    if (err_cnt == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
